/* rtl/tofe_pkg.sv */
// Shared types, codes and constants for the tick offset estimator.
package tofe_pkg;

  // Item operation codes.
  localparam logic [1:0] OP_OBSERVE = 2'd0;
  localparam logic [1:0] OP_QUERY   = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // Configuration register indexes.
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t REG_TICK_PERIOD = 2'd0;
  localparam cfg_idx_t REG_SNAP_LIMIT  = 2'd1;
  localparam cfg_idx_t REG_SLEW_LIMIT  = 2'd2;
  localparam cfg_idx_t REG_SLACK_TICKS = 2'd3;

  localparam int unsigned CFG_W = 20;

  // Register reset values.
  localparam logic [19:0] TICK_PERIOD_RST = 20'd16667;
  localparam logic [15:0] SNAP_LIMIT_RST  = 16'd8;
  localparam logic [15:0] SLEW_LIMIT_RST  = 16'd1;
  localparam logic [15:0] SLACK_TICKS_RST = 16'd2;

  // Flight estimate saturation and divider length.
  localparam logic [16:0] FLIGHT_CAP = 17'd65536;
  localparam int unsigned DIV_STEPS  = 32;
  localparam int unsigned CNT_W      = $clog2(DIV_STEPS);

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] authority_tick;
    logic [63:0] local_tick;
    logic [31:0] round_trip_us;
  } in_item_t;

  typedef struct packed {
    logic [63:0]        authority_estimate;
    logic [63:0]        command_tick;
    logic signed [63:0] offset_now;
    logic [16:0]        flight_now;
    logic signed [63:0] command_offset;
    logic               tracking;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic meas;
    logic flt;
    logic obs;
    logic diff;
    logic mag;
    logic upd;
    logic cmd_sum;
    logic est;
    logic out_load;
  } tofe_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic obs_go;
  } tofe_sts_t;

endpackage

/* rtl/tofe_ctrl.sv */
// Sequencing state machine of the tick offset estimator.
module tofe_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tofe_pkg::tofe_sts_t sts_i,
  output tofe_pkg::tofe_cmd_t cmd_o
);
  import tofe_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MEAS, ST_FLT, ST_OBS, ST_DIFF, ST_MAG, ST_UPD, ST_CMD,
    ST_EST, ST_DONE
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             accept, out_load;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && (state_q == ST_IDLE);
  // The result register is free when empty or being taken this cycle.
  assign out_load    = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  // Command decode.
  always_comb begin
    cmd_o          = '0;
    cmd_o.accept   = accept;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.meas     = (state_q == ST_MEAS);
    cmd_o.flt      = (state_q == ST_FLT);
    cmd_o.obs      = (state_q == ST_OBS);
    cmd_o.diff     = (state_q == ST_DIFF);
    cmd_o.mag      = (state_q == ST_MAG);
    cmd_o.upd      = (state_q == ST_UPD);
    cmd_o.cmd_sum  = (state_q == ST_CMD);
    cmd_o.est      = (state_q == ST_EST);
    cmd_o.out_load = out_load;
  end

  // Next state.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        if (in_valid_i) begin
          state_d = sts_i.obs_go ? ST_DIV : ST_CMD;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          state_d = ST_MEAS;
        end
      end
      ST_MEAS: state_d = ST_FLT;
      ST_FLT:  state_d = ST_OBS;
      ST_OBS:  state_d = ST_DIFF;
      ST_DIFF: state_d = ST_MAG;
      ST_MAG:  state_d = ST_UPD;
      ST_UPD:  state_d = ST_CMD;
      ST_CMD:  state_d = ST_EST;
      ST_EST:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/tofe_datapath.sv */
// Registers, divider and arithmetic of the tick offset estimator.
module tofe_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  tofe_pkg::cfg_idx_t          cfg_index_i,
  input  logic [tofe_pkg::CFG_W-1:0]  cfg_data_i,
  input  tofe_pkg::in_item_t          in_item_i,
  input  tofe_pkg::tofe_cmd_t         cmd_i,
  output tofe_pkg::tofe_sts_t         sts_o,
  output tofe_pkg::out_item_t         out_item_o
);
  import tofe_pkg::*;

  logic [19:0] tick_period_q;
  logic [15:0] snap_q, slew_q, slack_q;

  logic [63:0] auth_q, local_q;
  logic [20:0] rem_q;
  logic [31:0] quo_q;
  logic [16:0] meas_q;
  logic [63:0] t_q, obs_q, diff_q, mag_q, cmd_off_q, est_a_q, est_c_q;

  logic [63:0] offset_q;
  logic [16:0] flight_q;
  logic        seen_q;

  logic [20:0] den;
  logic [21:0] trial;
  logic        ge;
  logic [32:0] q_ceil;
  logic        snap_hit, slew_hit;
  logic [63:0] slew_ext, step;
  logic [64:0] sum_a, sum_c;
  logic [63:0] est_a_d, est_c_d;
  logic        is_clear;

  assign sts_o.obs_go = (in_item_i.op == OP_OBSERVE) && (tick_period_q != '0);
  assign is_clear     = (in_item_i.op == OP_CLEAR);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_period_q <= TICK_PERIOD_RST;
      snap_q        <= SNAP_LIMIT_RST;
      slew_q        <= SLEW_LIMIT_RST;
      slack_q       <= SLACK_TICKS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TICK_PERIOD: tick_period_q <= cfg_data_i[19:0];
        REG_SNAP_LIMIT:  snap_q        <= cfg_data_i[15:0];
        REG_SLEW_LIMIT:  slew_q        <= cfg_data_i[15:0];
        REG_SLACK_TICKS: slack_q       <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // Restoring divider step: one quotient bit per cycle.
  assign den   = {tick_period_q, 1'b0};
  assign trial = {rem_q, quo_q[31]};
  assign ge    = (trial >= {1'b0, den});

  // Ceiling of the quotient, saturated at the flight cap.
  assign q_ceil = {1'b0, quo_q} + 33'(rem_q != '0);

  // Offset update selection.
  assign snap_hit = (mag_q > {48'd0, snap_q});
  assign slew_hit = (mag_q > {48'd0, slew_q});
  assign slew_ext = {48'd0, slew_q};
  assign step     = slew_hit ? (diff_q[63] ? (64'd0 - slew_ext) : slew_ext) : diff_q;

  // Offset applied to the local tick; a negative result floors at zero.
  assign sum_a   = {1'b0, local_q} + {1'b0, offset_q};
  assign sum_c   = {1'b0, local_q} + {1'b0, cmd_off_q};
  assign est_a_d = (offset_q[63] && !sum_a[64]) ? 64'd0 : sum_a[63:0];
  assign est_c_d = (cmd_off_q[63] && !sum_c[64]) ? 64'd0 : sum_c[63:0];

  // Working registers of one item.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      auth_q  <= in_item_i.authority_tick;
      local_q <= in_item_i.local_tick;
      quo_q   <= in_item_i.round_trip_us;
      rem_q   <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? 21'(trial - {1'b0, den}) : trial[20:0];
      quo_q <= {quo_q[30:0], ge};
    end
    if (cmd_i.meas) begin
      meas_q <= (q_ceil > {16'd0, FLIGHT_CAP}) ? FLIGHT_CAP : q_ceil[16:0];
      t_q    <= auth_q - local_q;
    end
    if (cmd_i.obs) begin
      obs_q <= t_q + {47'd0, flight_q};
    end
    if (cmd_i.diff) begin
      diff_q <= obs_q - offset_q;
    end
    if (cmd_i.mag) begin
      mag_q <= diff_q[63] ? (64'd0 - diff_q) : diff_q;
    end
    if (cmd_i.cmd_sum) begin
      cmd_off_q <= offset_q + {47'd0, flight_q} + {48'd0, slack_q};
    end
    if (cmd_i.est) begin
      est_a_q <= est_a_d;
      est_c_q <= est_c_d;
    end
  end

  // Estimator state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      flight_q <= '0;
      seen_q   <= 1'b0;
    end else begin
      if (cmd_i.accept && is_clear) begin
        offset_q <= '0;
        flight_q <= '0;
        seen_q   <= 1'b0;
      end
      // Flight rises at once, otherwise decays by one tick per sample.
      if (cmd_i.flt) begin
        if (!seen_q || (meas_q > flight_q)) begin
          flight_q <= meas_q;
        end else if (flight_q > meas_q) begin
          flight_q <= flight_q - 1'b1;
        end
      end
      // First sample takes the measurement, a large error snaps, else slew.
      if (cmd_i.upd) begin
        if (!seen_q) begin
          offset_q <= obs_q;
          seen_q   <= 1'b1;
        end else if (snap_hit) begin
          offset_q <= obs_q;
        end else begin
          offset_q <= offset_q + step;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_item_o.authority_estimate <= est_a_q;
      out_item_o.command_tick       <= est_c_q;
      out_item_o.offset_now         <= offset_q;
      out_item_o.flight_now         <= flight_q;
      out_item_o.command_offset     <= cmd_off_q;
      out_item_o.tracking           <= seen_q;
    end
  end

endmodule

/* rtl/tick_offset_estimator.sv */
// Top level of the tick offset estimator: controller, datapath and checks.
// Observe item: the 32-step divider, then measure, flight, observe, difference,
// magnitude, update, command sum and estimate states lead to the result.
// Query, clear, or zero-period observe: command sum and estimate states only.
// One item at a time; the next item is taken while the result waits.
// Reset (asynchronous, active low) restores registers and estimator state.
module tick_offset_estimator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  tofe_pkg::cfg_idx_t          cfg_index_i,
  input  logic [tofe_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  tofe_pkg::in_item_t          in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output tofe_pkg::out_item_t         out_item_o
);
  import tofe_pkg::*;

  tofe_cmd_t cmd;
  tofe_sts_t sts;

  // Sequencer.
  tofe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic and state.
  tofe_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_item_o  (out_item_o)
  );

  // An accepted item blocks the input on the following cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted item");

  // Without a sample the estimate sits at its reset values.
  a_untracked_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.tracking) |->
      (out_item_o.offset_now == 64'sd0) && (out_item_o.flight_now == 17'd0))
    else $error("untracked result carries a nonzero estimate");

  // The flight estimate never exceeds its cap.
  a_flight_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.flight_now <= FLIGHT_CAP))
    else $error("flight estimate above cap");

endmodule
